### hdl/bpq_pkg.sv
// Shared constants, command and register codes, and controller state type for the packet queue.
package bpq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 256;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned ID_W       = 16;
    localparam int unsigned SIZE_W     = 16;
    localparam int unsigned LEN_W      = 9;
    localparam int unsigned BYTES_W    = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENQ_TAIL = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENQ_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_FRONT    = 2'd3;

    // configuration reset values
    localparam logic [LEN_W-1:0]   PACKET_LIMIT_RST = 9'd256;
    localparam logic [BYTES_W-1:0] BYTE_LIMIT_RST   = 24'hFFFFFF;

    localparam logic [LEN_W-1:0]   LEN_MAX   = 9'h1FF;
    localparam logic [BYTES_W-1:0] BYTES_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DROP,
        S_POP,
        S_SCAN,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } t_state;

endpackage

### hdl/bounded_packet_queue_drop_policy.sv
// Packet descriptor queue with drop-tail / drop-front overflow policy, in one descriptor RAM.
//
// Holds up to QUEUE_DEPTH descriptors (16-bit id, 16-bit byte size) in a ring in one
// synchronous RAM with a registered read. Commands: enqueue at tail, enqueue at head, dequeue,
// remove by id, flush; codes 5 to 7 do nothing and only report status. One command is worked
// at a time and every command yields exactly one result transfer. An enqueue without a RAM
// read and a flush go straight to the result; a dequeue of a non-empty queue and a drop-front
// overflow that swaps out the head first read the head slot; remove by id scans from the head -
// the scan reads one entry per cycle through the RAM read port, and closing the gap moves each
// entry with a read, then a write. A new command is taken once the controller is back in
// idle, even while the previous result still waits on the output register; it only holds
// in its final step if that register is still full.
// Configuration writes are expected only while the queue is idle; there is no clearing pass.
module bounded_packet_queue_drop_policy #(
    parameter int unsigned QUEUE_DEPTH = bpq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [bpq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // command channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bpq_pkg::CMD_W-1:0]       i_command,
    input  logic [bpq_pkg::ID_W-1:0]        i_packet_id,
    input  logic [bpq_pkg::SIZE_W-1:0]      i_packet_size,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_item_valid,
    output logic [bpq_pkg::ID_W-1:0]        o_item_id,
    output logic [bpq_pkg::SIZE_W-1:0]      o_item_size,
    output logic                            o_drop_flag,
    output logic [bpq_pkg::ID_W-1:0]        o_drop_id,
    output logic [bpq_pkg::LEN_W-1:0]       o_queue_length,
    output logic [bpq_pkg::BYTES_W-1:0]     o_queue_bytes
);

    // slot index, count, exact byte total and comparison widths
    localparam int unsigned AW   = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned BW   = bpq_pkg::SIZE_W + CW;
    localparam int unsigned CMPW = (BW > bpq_pkg::BYTES_W) ? BW : bpq_pkg::BYTES_W;
    localparam int unsigned LW   = (CW > bpq_pkg::LEN_W) ? CW : bpq_pkg::LEN_W;
    localparam int unsigned EW   = bpq_pkg::ID_W + bpq_pkg::SIZE_W;

    localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] DEPTH_L   = LW'(QUEUE_DEPTH);

    // ring arithmetic on slot indexes, both operands below the depth
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
        return (a == LAST_SLOT) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_SLOT : a - 1'b1;
    endfunction

    // ---------------------------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------------------------
    logic [bpq_pkg::LEN_W-1:0]   r_packet_limit;
    logic                        r_byte_limit_en;
    logic [bpq_pkg::BYTES_W-1:0] r_byte_limit;
    logic                        r_drop_front;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_limit  <= bpq_pkg::PACKET_LIMIT_RST;
            r_byte_limit_en <= 1'b0;
            r_byte_limit    <= bpq_pkg::BYTE_LIMIT_RST;
            r_drop_front    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpq_pkg::REG_PACKET_LIMIT:  r_packet_limit  <= i_cfg_data[bpq_pkg::LEN_W-1:0];
                bpq_pkg::REG_BYTE_LIMIT_EN: r_byte_limit_en <= i_cfg_data[0];
                bpq_pkg::REG_BYTE_LIMIT:    r_byte_limit    <= i_cfg_data;
                bpq_pkg::REG_DROP_FRONT:    r_drop_front    <= i_cfg_data[0];
            endcase
        end
    end

    // ---------------------------------------------------------------------------------------
    // Descriptor RAM: {id, size} per slot, one write and one registered read per cycle.
    // Contents are undefined until written; the ring bookkeeping never reads a stale slot.
    // ---------------------------------------------------------------------------------------
    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [EW-1:0] mem_wr_data;
    logic [EW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rdata <= mem[mem_rd_addr];
        end
    end

    logic [bpq_pkg::ID_W-1:0]   rd_id;
    logic [bpq_pkg::SIZE_W-1:0] rd_size;
    assign rd_id   = r_rdata[EW-1:bpq_pkg::SIZE_W];
    assign rd_size = r_rdata[bpq_pkg::SIZE_W-1:0];

    // ---------------------------------------------------------------------------------------
    // Controller and queue state
    // ---------------------------------------------------------------------------------------
    bpq_pkg::t_state r_state, n_state;

    logic [bpq_pkg::CMD_W-1:0]  r_cmd;
    logic [bpq_pkg::ID_W-1:0]   r_pid;
    logic [bpq_pkg::SIZE_W-1:0] r_psz;

    logic [AW-1:0] r_head,  n_head;
    logic [CW-1:0] r_count, n_count;
    logic [BW-1:0] r_total, n_total;

    // scan / close-up position, and the compare stage of the scan
    logic [CW-1:0] r_k,     n_k;
    logic [CW-1:0] r_cmp_k, n_cmp_k;
    logic          r_pend,  n_pend;

    // result of the command under way
    logic                       r_res_valid, n_res_valid;
    logic [bpq_pkg::ID_W-1:0]   r_res_iid,   n_res_iid;
    logic [bpq_pkg::SIZE_W-1:0] r_res_isz,   n_res_isz;
    logic                       r_res_drop,  n_res_drop;
    logic [bpq_pkg::ID_W-1:0]   r_res_did,   n_res_did;

    // output register
    logic                        r_out_valid;
    logic                        r_o_item_valid;
    logic [bpq_pkg::ID_W-1:0]    r_o_item_id;
    logic [bpq_pkg::SIZE_W-1:0]  r_o_item_size;
    logic                        r_o_drop_flag;
    logic [bpq_pkg::ID_W-1:0]    r_o_drop_id;
    logic [bpq_pkg::LEN_W-1:0]   r_o_queue_length;
    logic [bpq_pkg::BYTES_W-1:0] r_o_queue_bytes;

    logic in_xfer;
    logic out_load;

    assign o_in_ready = (r_state == bpq_pkg::S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == bpq_pkg::S_RESP) && (!r_out_valid || i_out_ready);

    // ---------------------------------------------------------------------------------------
    // Decisions shared by the next-state and datapath logic
    // ---------------------------------------------------------------------------------------
    logic [LW-1:0]   eff_limit;
    logic            over_count;
    logic            over_bytes;
    logic            overflow;
    logic            is_enq;
    logic            empty;
    logic            scan_match;
    logic            scan_more;
    logic [CW-1:0]   k_next;
    logic            shift_more;
    logic [CMPW-1:0] bytes_after;

    assign eff_limit   = (LW'(r_packet_limit) > DEPTH_L) ? DEPTH_L : LW'(r_packet_limit);
    assign over_count  = LW'(r_count) >= eff_limit;
    assign bytes_after = CMPW'(r_total) + CMPW'(r_psz);
    assign over_bytes  = r_byte_limit_en && (bytes_after > CMPW'(r_byte_limit));
    assign overflow    = over_count || over_bytes;
    assign is_enq      = (r_cmd == bpq_pkg::CMD_ENQ_TAIL) || (r_cmd == bpq_pkg::CMD_ENQ_HEAD);
    assign empty       = (r_count == '0);
    assign scan_match  = r_pend && (rd_id == r_pid);
    assign scan_more   = r_k < r_count;
    assign k_next      = r_k + 1'b1;
    assign shift_more  = k_next < r_count;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpq_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = bpq_pkg::S_EXEC;
                end
            end
            bpq_pkg::S_EXEC: begin
                n_state = bpq_pkg::S_RESP;
                if (is_enq && overflow && r_drop_front && !empty) begin
                    n_state = bpq_pkg::S_DROP;
                end else if ((r_cmd == bpq_pkg::CMD_DEQUEUE) && !empty) begin
                    n_state = bpq_pkg::S_POP;
                end else if (r_cmd == bpq_pkg::CMD_REMOVE) begin
                    n_state = bpq_pkg::S_SCAN;
                end
            end
            bpq_pkg::S_DROP:  n_state = bpq_pkg::S_RESP;
            bpq_pkg::S_POP:   n_state = bpq_pkg::S_RESP;
            bpq_pkg::S_SCAN: begin
                if (scan_match) begin
                    n_state = bpq_pkg::S_SH_RD;
                end else if (!scan_more) begin
                    n_state = bpq_pkg::S_RESP;
                end
            end
            bpq_pkg::S_SH_RD: n_state = shift_more ? bpq_pkg::S_SH_WR : bpq_pkg::S_RESP;
            bpq_pkg::S_SH_WR: n_state = bpq_pkg::S_SH_RD;
            bpq_pkg::S_RESP: begin
                if (out_load) begin
                    n_state = bpq_pkg::S_IDLE;
                end
            end
            default: n_state = bpq_pkg::S_IDLE;
        endcase
    end

    // datapath: queue state, RAM accesses and result fields
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_total     = r_total;
        n_k         = r_k;
        n_cmp_k     = r_cmp_k;
        n_pend      = r_pend;
        n_res_valid = r_res_valid;
        n_res_iid   = r_res_iid;
        n_res_isz   = r_res_isz;
        n_res_drop  = r_res_drop;
        n_res_did   = r_res_did;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_head;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_head;
        mem_wr_data = {r_pid, r_psz};

        unique case (r_state)
            bpq_pkg::S_EXEC: begin
                n_res_valid = 1'b0;
                n_res_iid   = '0;
                n_res_isz   = '0;
                n_res_drop  = 1'b0;
                n_res_did   = '0;
                n_k         = '0;
                n_pend      = 1'b0;
                case (r_cmd) inside
                    bpq_pkg::CMD_ENQ_TAIL, bpq_pkg::CMD_ENQ_HEAD: begin
                        if (!overflow || (r_drop_front && empty
                                          && (r_cmd == bpq_pkg::CMD_ENQ_HEAD))) begin
                            // plain insert; an empty head insert in drop-front skips the drop
                            mem_wr_en = 1'b1;
                            if (r_cmd == bpq_pkg::CMD_ENQ_TAIL) begin
                                mem_wr_addr = slot_add(r_head, r_count[AW-1:0]);
                            end else begin
                                n_head      = slot_dec(r_head);
                                mem_wr_addr = slot_dec(r_head);
                            end
                            n_count = r_count + 1'b1;
                            n_total = r_total + BW'(r_psz);
                        end else if (r_drop_front && !empty) begin
                            mem_rd_en = 1'b1;   // fetch the head to discard it
                        end else begin
                            n_res_drop = 1'b1;  // new packet discarded
                            n_res_did  = r_pid;
                        end
                    end
                    bpq_pkg::CMD_DEQUEUE: begin
                        mem_rd_en = !empty;
                    end
                    bpq_pkg::CMD_FLUSH: begin
                        n_head  = '0;
                        n_count = '0;
                        n_total = '0;
                    end
                    default: ;
                endcase
            end
            bpq_pkg::S_DROP: begin
                // head leaves, new packet goes in; count unchanged
                n_res_drop  = 1'b1;
                n_res_did   = rd_id;
                n_total     = r_total - BW'(rd_size) + BW'(r_psz);
                mem_wr_en   = 1'b1;
                if (r_cmd == bpq_pkg::CMD_ENQ_TAIL) begin
                    n_head      = slot_inc(r_head);
                    mem_wr_addr = slot_add(slot_inc(r_head), AW'(r_count - 1'b1));
                end else begin
                    mem_wr_addr = r_head;
                end
            end
            bpq_pkg::S_POP: begin
                n_res_valid = 1'b1;
                n_res_iid   = rd_id;
                n_res_isz   = rd_size;
                n_head      = slot_inc(r_head);
                n_count     = r_count - 1'b1;
                n_total     = r_total - BW'(rd_size);
            end
            bpq_pkg::S_SCAN: begin
                if (scan_match) begin
                    n_res_valid = 1'b1;
                    n_res_iid   = rd_id;
                    n_res_isz   = rd_size;
                    n_total     = r_total - BW'(rd_size);
                    n_k         = r_cmp_k;
                    n_pend      = 1'b0;
                end else if (scan_more) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_add(r_head, r_k[AW-1:0]);
                    n_pend      = 1'b1;
                    n_cmp_k     = r_k;
                    n_k         = k_next;
                end
            end
            bpq_pkg::S_SH_RD: begin
                if (shift_more) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_add(r_head, k_next[AW-1:0]);
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            bpq_pkg::S_SH_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = slot_add(r_head, r_k[AW-1:0]);
                mem_wr_data = r_rdata;
                n_k         = k_next;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpq_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_total <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_total <= n_total;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= i_command;
            r_pid <= i_packet_id;
            r_psz <= i_packet_size;
        end
        r_k         <= n_k;
        r_cmp_k     <= n_cmp_k;
        r_res_valid <= n_res_valid;
        r_res_iid   <= n_res_iid;
        r_res_isz   <= n_res_isz;
        r_res_drop  <= n_res_drop;
        r_res_did   <= n_res_did;
    end

    // ---------------------------------------------------------------------------------------
    // Output register; length and byte total are reported saturated
    // ---------------------------------------------------------------------------------------
    logic [LW-1:0]   count_x;
    logic [CMPW-1:0] total_x;

    assign count_x = LW'(r_count);
    assign total_x = CMPW'(r_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_item_valid   <= r_res_valid;
            r_o_item_id      <= r_res_iid;
            r_o_item_size    <= r_res_isz;
            r_o_drop_flag    <= r_res_drop;
            r_o_drop_id      <= r_res_did;
            r_o_queue_length <= (count_x > LW'(bpq_pkg::LEN_MAX))
                                ? bpq_pkg::LEN_MAX : count_x[bpq_pkg::LEN_W-1:0];
            r_o_queue_bytes  <= (total_x > CMPW'(bpq_pkg::BYTES_MAX))
                                ? bpq_pkg::BYTES_MAX : total_x[bpq_pkg::BYTES_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_item_valid   = r_o_item_valid;
    assign o_item_id      = r_o_item_id;
    assign o_item_size    = r_o_item_size;
    assign o_drop_flag    = r_o_drop_flag;
    assign o_drop_id      = r_o_drop_id;
    assign o_queue_length = r_o_queue_length;
    assign o_queue_bytes  = r_o_queue_bytes;

endmodule
